// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define SCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define SCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define SCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// SPI NOR command sequencer package
// Payload types, command codes and result builders shared by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

    // Request and reply codes on the input channel.
    localparam logic [2:0] MODE_READ_ID = 3'd0;
    localparam logic [2:0] MODE_ERASE   = 3'd1;
    localparam logic [2:0] MODE_PROGRAM = 3'd2;
    localparam logic [2:0] MODE_READ    = 3'd3;
    localparam logic [2:0] MODE_DATA    = 3'd4;
    localparam logic [2:0] MODE_REPLY   = 3'd5;

    // Result kinds.
    localparam logic [2:0] KIND_XFER  = 3'd0;
    localparam logic [2:0] KIND_DREQ  = 3'd1;
    localparam logic [2:0] KIND_RDATA = 3'd2;
    localparam logic [2:0] KIND_ID    = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;

    // Flash opcodes.
    localparam logic [7:0] OPC_READ_ID = 8'h9f;
    localparam logic [7:0] OPC_WREN    = 8'h06;
    localparam logic [7:0] OPC_WRDI    = 8'h04;
    localparam logic [7:0] OPC_RDSR    = 8'h05;
    localparam logic [7:0] OPC_SE      = 8'h20;
    localparam logic [7:0] OPC_PP      = 8'h02;
    localparam logic [7:0] OPC_READ    = 8'h03;
    localparam logic [7:0] DUMMY_BYTE  = 8'hff;
    localparam logic [7:0] STATUS_BUSY = 8'h01;

    // Queue between the sequencer and the result side.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_POLL_CMD,
        PH_POLL_DATA,
        PH_WREN,
        PH_CMD,
        PH_ADDR_H,
        PH_ADDR_M,
        PH_ADDR_L,
        PH_ID1,
        PH_ID2,
        PH_ID3,
        PH_DATA_REQ,
        PH_DATA,
        PH_WRDI,
        PH_FPOLL_CMD,
        PH_FPOLL_DATA
    } phase_t;

    typedef enum logic [1:0] {
        OP_ID,
        OP_ERASE,
        OP_PROG,
        OP_READ
    } op_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [5:0]  block_number;
        logic [3:0]  sector_number;
        logic [3:0]  page_number;
        logic [7:0]  byte_offset;
        logic [15:0] transfer_length;
        logic [7:0]  payload_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  mosi_byte;
        logic        frame_start;
        logic        frame_end;
        logic [7:0]  read_byte;
        logic [7:0]  manufacturer_id;
        logic [15:0] device_id;
        logic        last;
    } result_t;

    // One queue entry holds every result of one input item.
    typedef struct packed {
        result_t res_a;
        result_t res_b;
        logic    pair;
    } entry_t;

    typedef struct packed {
        logic   wr_en;
        entry_t entry;
    } fifo_wr_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    function automatic result_t xfer_result(input logic [7:0] mosi, input logic fs,
                                            input logic fe);
        result_t r;
        r             = '0;
        r.kind        = KIND_XFER;
        r.mosi_byte   = mosi;
        r.frame_start = fs;
        r.frame_end   = fe;
        return r;
    endfunction

    function automatic result_t kind_result(input logic [2:0] kind);
        result_t r;
        r      = '0;
        r.kind = kind;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/spi_nor_flash_command_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer
// Turns read ID, erase, program and read requests into single-byte SPI
// transfers with chip select marks, status polling and write enable/disable.
// ----------------------------------------------------------------------------
//  Channel   Handshake        Payload            Transfer when
//  request   push / full      item   (item_t)    push && !full
//  result    empty / pop      result (result_t)  pop && !empty
//
// An item is taken every cycle while the four-entry result queue has room; its
// results are in the queue in the next cycle. The result side gives one result
// per pop, so an item with two results holds its queue entry for two pops.
// Reset clears the sequencer to idle and empties the queue; no clearing pass.
// Only a full queue stalls the request side.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spi_nor_flash_command_sequencer_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire scs_pkg::item_t    item,
    output logic                   empty,
    input  wire logic              pop,
    output scs_pkg::result_t       result
);

    scs_pkg::fifo_wr_t     fifo_wr;
    scs_pkg::entry_t       fifo_head;
    scs_pkg::fifo_status_t fifo_status;
    logic                  fifo_rd;
    logic                  accept;

    assign full   = fifo_status.full;
    assign accept = push && !fifo_status.full;

    scs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .wr     (fifo_wr)
    );

    scs_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (fifo_wr),
        .rd_en  (fifo_rd),
        .head   (fifo_head),
        .status (fifo_status)
    );

    scs_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (fifo_head),
        .status (fifo_status),
        .pop    (pop),
        .rd_en  (fifo_rd),
        .empty  (empty),
        .result (result)
    );

    `SCS_ASSERT(a_no_write_when_full, clk, rst_n, !(fifo_wr.wr_en && fifo_status.full), "queue written while full")
    `SCS_ASSERT_IMPL(a_frame_marks_on_xfer, clk, rst_n, !empty && result.kind != scs_pkg::KIND_XFER, !result.frame_start && !result.frame_end, "frame mark on a non-transfer result")
    `SCS_ASSERT_IMPL(a_done_is_last, clk, rst_n, !empty && result.kind == scs_pkg::KIND_DONE, result.last, "completion not marked last")

endmodule

`default_nettype wire

// ===== rtl/scs_front.sv =====
// ----------------------------------------------------------------------------
// Sequencer front end
// Takes requests, data bytes and SPI replies, steps the command sequence and
// writes the results of each item into the queue as one entry.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire scs_pkg::item_t    item,
    output scs_pkg::fifo_wr_t      wr
);

    scs_pkg::phase_t phase_reg, phase_next;
    scs_pkg::op_t    op_reg, op_next;
    logic [23:0]     addr_reg, addr_next;
    logic [15:0]     remain_reg, remain_next;
    logic [7:0]      id_first_reg, id_first_next;
    logic [7:0]      id_high_reg, id_high_next;

    logic [15:0]     remain_dec;
    logic            rx_busy;
    logic            is_erase_req;

    assign remain_dec   = remain_reg - 16'd1;
    assign rx_busy      = |(item.payload_byte & scs_pkg::STATUS_BUSY);
    assign is_erase_req = (item.mode == scs_pkg::MODE_ERASE);

    // Next state.
    always_comb
    begin
        phase_next    = phase_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        remain_next   = remain_reg;
        id_first_next = id_first_reg;
        id_high_next  = id_high_reg;
        if (accept)
        begin
            unique case (item.mode) inside
                scs_pkg::MODE_READ_ID, scs_pkg::MODE_ERASE,
                scs_pkg::MODE_PROGRAM, scs_pkg::MODE_READ:
                begin
                    if (phase_reg == scs_pkg::PH_IDLE)
                    begin
                        op_next     = scs_pkg::op_t'(item.mode[1:0]);
                        remain_next = item.transfer_length;
                        addr_next   = {2'b00, item.block_number, item.sector_number,
                                       is_erase_req ? 4'd0 : item.page_number,
                                       is_erase_req ? 8'd0 : item.byte_offset};
                        phase_next  = (item.mode == scs_pkg::MODE_READ_ID)
                                      ? scs_pkg::PH_CMD : scs_pkg::PH_POLL_CMD;
                    end
                end
                scs_pkg::MODE_DATA:
                begin
                    if (phase_reg == scs_pkg::PH_DATA_REQ)
                        phase_next = scs_pkg::PH_DATA;
                end
                scs_pkg::MODE_REPLY:
                begin
                    unique case (phase_reg)
                        scs_pkg::PH_POLL_CMD:  phase_next = scs_pkg::PH_POLL_DATA;
                        scs_pkg::PH_POLL_DATA:
                        begin
                            if (rx_busy)
                                phase_next = scs_pkg::PH_POLL_CMD;
                            else if (op_reg == scs_pkg::OP_READ)
                                phase_next = scs_pkg::PH_CMD;
                            else
                                phase_next = scs_pkg::PH_WREN;
                        end
                        scs_pkg::PH_WREN:      phase_next = scs_pkg::PH_CMD;
                        scs_pkg::PH_CMD:
                        begin
                            phase_next = (op_reg == scs_pkg::OP_ID)
                                         ? scs_pkg::PH_ID1 : scs_pkg::PH_ADDR_H;
                        end
                        scs_pkg::PH_ID1:
                        begin
                            id_first_next = item.payload_byte;
                            phase_next    = scs_pkg::PH_ID2;
                        end
                        scs_pkg::PH_ID2:
                        begin
                            id_high_next = item.payload_byte;
                            phase_next   = scs_pkg::PH_ID3;
                        end
                        scs_pkg::PH_ID3:       phase_next = scs_pkg::PH_IDLE;
                        scs_pkg::PH_ADDR_H:    phase_next = scs_pkg::PH_ADDR_M;
                        scs_pkg::PH_ADDR_M:    phase_next = scs_pkg::PH_ADDR_L;
                        scs_pkg::PH_ADDR_L:
                        begin
                            if (op_reg == scs_pkg::OP_ERASE)
                                phase_next = scs_pkg::PH_FPOLL_CMD;
                            else if (op_reg == scs_pkg::OP_PROG)
                                phase_next = (remain_reg != 16'd0)
                                             ? scs_pkg::PH_DATA_REQ : scs_pkg::PH_WRDI;
                            else
                                phase_next = (remain_reg != 16'd0)
                                             ? scs_pkg::PH_DATA : scs_pkg::PH_IDLE;
                        end
                        scs_pkg::PH_DATA:
                        begin
                            remain_next = remain_dec;
                            if (op_reg == scs_pkg::OP_READ)
                                phase_next = (remain_dec != 16'd0)
                                             ? scs_pkg::PH_DATA : scs_pkg::PH_IDLE;
                            else
                                phase_next = (remain_dec != 16'd0)
                                             ? scs_pkg::PH_DATA_REQ : scs_pkg::PH_WRDI;
                        end
                        scs_pkg::PH_WRDI:      phase_next = scs_pkg::PH_IDLE;
                        scs_pkg::PH_FPOLL_CMD: phase_next = scs_pkg::PH_FPOLL_DATA;
                        scs_pkg::PH_FPOLL_DATA:
                        begin
                            phase_next = rx_busy ? scs_pkg::PH_FPOLL_CMD : scs_pkg::PH_IDLE;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Results of the accepted item.
    always_comb
    begin
        wr = '0;
        if (accept)
        begin
            unique case (item.mode) inside
                scs_pkg::MODE_READ_ID, scs_pkg::MODE_ERASE,
                scs_pkg::MODE_PROGRAM, scs_pkg::MODE_READ:
                begin
                    if (phase_reg == scs_pkg::PH_IDLE)
                    begin
                        wr.wr_en       = 1'b1;
                        wr.entry.res_a = scs_pkg::xfer_result(
                            (item.mode == scs_pkg::MODE_READ_ID)
                            ? scs_pkg::OPC_READ_ID : scs_pkg::OPC_RDSR, 1'b1, 1'b0);
                    end
                end
                scs_pkg::MODE_DATA:
                begin
                    if (phase_reg == scs_pkg::PH_DATA_REQ)
                    begin
                        wr.wr_en       = 1'b1;
                        wr.entry.res_a = scs_pkg::xfer_result(item.payload_byte, 1'b0,
                                                              remain_reg == 16'd1);
                    end
                end
                scs_pkg::MODE_REPLY:
                begin
                    wr.wr_en = 1'b1;
                    unique case (phase_reg) inside
                        scs_pkg::PH_POLL_CMD, scs_pkg::PH_FPOLL_CMD:
                        begin
                            wr.entry.res_a = scs_pkg::xfer_result(scs_pkg::DUMMY_BYTE,
                                                                  1'b0, 1'b1);
                        end
                        scs_pkg::PH_POLL_DATA:
                        begin
                            if (rx_busy)
                                wr.entry.res_a = scs_pkg::xfer_result(scs_pkg::OPC_RDSR,
                                                                      1'b1, 1'b0);
                            else if (op_reg == scs_pkg::OP_READ)
                                wr.entry.res_a = scs_pkg::xfer_result(scs_pkg::OPC_READ,
                                                                      1'b1, 1'b0);
                            else
                                wr.entry.res_a = scs_pkg::xfer_result(scs_pkg::OPC_WREN,
                                                                      1'b1, 1'b1);
                        end
                        scs_pkg::PH_WREN:
                        begin
                            wr.entry.res_a = scs_pkg::xfer_result(
                                (op_reg == scs_pkg::OP_ERASE)
                                ? scs_pkg::OPC_SE : scs_pkg::OPC_PP, 1'b1, 1'b0);
                        end
                        scs_pkg::PH_CMD:
                        begin
                            wr.entry.res_a = scs_pkg::xfer_result(
                                (op_reg == scs_pkg::OP_ID)
                                ? scs_pkg::DUMMY_BYTE : addr_reg[23:16], 1'b0, 1'b0);
                        end
                        scs_pkg::PH_ID1:
                        begin
                            wr.entry.res_a = scs_pkg::xfer_result(scs_pkg::DUMMY_BYTE,
                                                                  1'b0, 1'b0);
                        end
                        scs_pkg::PH_ID2:
                        begin
                            wr.entry.res_a = scs_pkg::xfer_result(scs_pkg::DUMMY_BYTE,
                                                                  1'b0, 1'b1);
                        end
                        scs_pkg::PH_ID3:
                        begin
                            wr.entry.res_a = scs_pkg::kind_result(scs_pkg::KIND_ID);
                            wr.entry.res_a.manufacturer_id = id_first_reg;
                            wr.entry.res_a.device_id = {id_high_reg, item.payload_byte};
                            wr.entry.res_b = scs_pkg::kind_result(scs_pkg::KIND_DONE);
                            wr.entry.pair  = 1'b1;
                        end
                        scs_pkg::PH_ADDR_H:
                        begin
                            wr.entry.res_a = scs_pkg::xfer_result(addr_reg[15:8],
                                                                  1'b0, 1'b0);
                        end
                        scs_pkg::PH_ADDR_M:
                        begin
                            wr.entry.res_a = scs_pkg::xfer_result(addr_reg[7:0], 1'b0,
                                (op_reg == scs_pkg::OP_ERASE) || (remain_reg == 16'd0));
                        end
                        scs_pkg::PH_ADDR_L:
                        begin
                            if (op_reg == scs_pkg::OP_ERASE)
                                wr.entry.res_a = scs_pkg::xfer_result(scs_pkg::OPC_RDSR,
                                                                      1'b1, 1'b0);
                            else if (op_reg == scs_pkg::OP_PROG)
                            begin
                                if (remain_reg != 16'd0)
                                    wr.entry.res_a = scs_pkg::kind_result(
                                        scs_pkg::KIND_DREQ);
                                else
                                    wr.entry.res_a = scs_pkg::xfer_result(
                                        scs_pkg::OPC_WRDI, 1'b1, 1'b1);
                            end
                            else if (remain_reg != 16'd0)
                                wr.entry.res_a = scs_pkg::xfer_result(scs_pkg::DUMMY_BYTE,
                                    1'b0, remain_reg == 16'd1);
                            else
                                wr.entry.res_a = scs_pkg::kind_result(scs_pkg::KIND_DONE);
                        end
                        scs_pkg::PH_DATA:
                        begin
                            if (op_reg == scs_pkg::OP_READ)
                            begin
                                // The read byte goes out first, then the next
                                // dummy transfer or the completion.
                                wr.entry.res_a = scs_pkg::kind_result(scs_pkg::KIND_RDATA);
                                wr.entry.res_a.read_byte = item.payload_byte;
                                wr.entry.pair = 1'b1;
                                if (remain_dec != 16'd0)
                                    wr.entry.res_b = scs_pkg::xfer_result(
                                        scs_pkg::DUMMY_BYTE, 1'b0, remain_dec == 16'd1);
                                else
                                    wr.entry.res_b = scs_pkg::kind_result(
                                        scs_pkg::KIND_DONE);
                            end
                            else if (remain_dec != 16'd0)
                                wr.entry.res_a = scs_pkg::kind_result(scs_pkg::KIND_DREQ);
                            else
                                wr.entry.res_a = scs_pkg::xfer_result(scs_pkg::OPC_WRDI,
                                                                      1'b1, 1'b1);
                        end
                        scs_pkg::PH_WRDI:
                        begin
                            wr.entry.res_a = scs_pkg::kind_result(scs_pkg::KIND_DONE);
                        end
                        scs_pkg::PH_FPOLL_DATA:
                        begin
                            if (rx_busy)
                                wr.entry.res_a = scs_pkg::xfer_result(scs_pkg::OPC_RDSR,
                                                                      1'b1, 1'b0);
                            else
                                wr.entry.res_a = scs_pkg::kind_result(scs_pkg::KIND_DONE);
                        end
                        default:
                        begin
                            // No transfer outstanding: the reply is dropped.
                            wr.wr_en = 1'b0;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= scs_pkg::PH_IDLE;
            op_reg       <= scs_pkg::OP_ID;
            addr_reg     <= '0;
            remain_reg   <= '0;
            id_first_reg <= '0;
            id_high_reg  <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            op_reg       <= op_next;
            addr_reg     <= addr_next;
            remain_reg   <= remain_next;
            id_first_reg <= id_first_next;
            id_high_reg  <= id_high_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scs_fifo.sv =====
// ----------------------------------------------------------------------------
// Sequencer result queue
// Short queue of result entries between the front end and the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire scs_pkg::fifo_wr_t   wr,
    input  wire logic                rd_en,
    output scs_pkg::entry_t          head,
    output scs_pkg::fifo_status_t    status
);

    scs_pkg::entry_t                    entries_reg [scs_pkg::FIFO_DEPTH];
    logic [scs_pkg::FIFO_AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [scs_pkg::FIFO_AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [scs_pkg::FIFO_CW-1:0]        count_reg, count_next;
    logic                               do_wr;
    logic                               do_rd;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == scs_pkg::FIFO_CW'(scs_pkg::FIFO_DEPTH));
    assign do_wr        = wr.wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign head         = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + scs_pkg::FIFO_AW'(do_wr);
        rd_ptr_next = rd_ptr_reg + scs_pkg::FIFO_AW'(do_rd);
        count_next  = count_reg + scs_pkg::FIFO_CW'(do_wr) - scs_pkg::FIFO_CW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries_reg[wr_ptr_reg] <= wr.entry;
    end

endmodule

`default_nettype wire

// ===== rtl/scs_back.sv =====
// ----------------------------------------------------------------------------
// Sequencer result side
// Hands out the results of the head entry one at a time and marks the last.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire scs_pkg::entry_t       head,
    input  wire scs_pkg::fifo_status_t status,
    input  wire logic                  pop,
    output logic                       rd_en,
    output logic                       empty,
    output scs_pkg::result_t           result
);

    logic sel_b_reg, sel_b_next;
    logic taken;
    logic final_res;

    assign empty     = status.empty;
    assign taken     = pop && !status.empty;
    assign final_res = sel_b_reg || !head.pair;
    assign rd_en     = taken && final_res;

    always_comb
    begin
        result      = sel_b_reg ? head.res_b : head.res_a;
        result.last = final_res;
    end

    always_comb
    begin
        sel_b_next = sel_b_reg;
        if (taken)
            sel_b_next = !final_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_b_reg <= 1'b0;
        else
            sel_b_reg <= sel_b_next;
    end

endmodule

`default_nettype wire
